[design/srt_pkg.sv]
package srt_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int COORD_BITS_DEF    = 12;
    localparam int ID_BITS           = 16;
    localparam int FLAG_BITS         = 2;
    localparam int CMD_BITS          = 2;
    localparam int COUNT_OUT_BITS    = 7;

    typedef logic [CMD_BITS-1:0] t_cmd;

    localparam t_cmd CMD_INSERT = 2'd0;
    localparam t_cmd CMD_REMOVE = 2'd1;
    localparam t_cmd CMD_FIND   = 2'd2;

endpackage

[design/srt_if.sv]
interface srt_in_if #(
    parameter int COORD_BITS = srt_pkg::COORD_BITS_DEF
);
    logic                           valid;
    logic                           ready;
    srt_pkg::t_cmd                  command;
    logic [COORD_BITS-1:0]          pos_x;
    logic [COORD_BITS-1:0]          pos_y;
    logic [srt_pkg::ID_BITS-1:0]    stamp_id;
    logic [COORD_BITS-1:0]          stamp_width;
    logic [COORD_BITS-1:0]          stamp_height;
    logic [srt_pkg::FLAG_BITS-1:0]  flip_flags;

    modport source (
        output valid, command, pos_x, pos_y, stamp_id, stamp_width, stamp_height, flip_flags,
        input  ready
    );
    modport sink (
        input  valid, command, pos_x, pos_y, stamp_id, stamp_width, stamp_height, flip_flags,
        output ready
    );
endinterface

interface srt_out_if #(
    parameter int COORD_BITS = srt_pkg::COORD_BITS_DEF
);
    logic                                valid;
    logic                                ready;
    logic                                hit;
    logic                                table_full;
    logic [srt_pkg::ID_BITS-1:0]         found_id;
    logic [COORD_BITS-1:0]               left_x;
    logic [COORD_BITS-1:0]               top_y;
    logic [srt_pkg::FLAG_BITS-1:0]       found_flags;
    logic [srt_pkg::COUNT_OUT_BITS-1:0]  entry_count;

    modport source (
        output valid, hit, table_full, found_id, left_x, top_y, found_flags, entry_count,
        input  ready
    );
    modport sink (
        input  valid, hit, table_full, found_id, left_x, top_y, found_flags, entry_count,
        output ready
    );
endinterface

[design/stamp_rectangle_table.sv]
// Insert, the unused command, and find or remove on an empty table go straight
// from accept to ST_OUT. Find and remove otherwise scan, one table read per cycle;
// a remove hit then passes through ST_MOVE_RD and ST_MOVE_WR to move the last
// entry into the freed slot. One word in flight; ready only while idle, so the
// next word can be taken in the cycle after the result register loads.
// Reset (synchronous, active low) empties the table; entry storage is not cleared.
module stamp_rectangle_table #(
    parameter int TABLE_ENTRIES = srt_pkg::TABLE_ENTRIES_DEF,
    parameter int COORD_BITS    = srt_pkg::COORD_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    srt_in_if.sink     i_in,
    srt_out_if.source  o_out
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int CW = $clog2(TABLE_ENTRIES + 1);
    localparam int CB = COORD_BITS;
    localparam int IB = srt_pkg::ID_BITS;
    localparam int FB = srt_pkg::FLAG_BITS;
    localparam int OB = srt_pkg::COUNT_OUT_BITS;
    // word: {id, flags, height, width, row, column}
    localparam int WW = IB + FB + 4 * CB;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SCAN    = 3'd1;
    localparam logic [2:0] ST_MOVE_RD = 3'd2;
    localparam logic [2:0] ST_MOVE_WR = 3'd3;
    localparam logic [2:0] ST_OUT     = 3'd4;

    logic [2:0]          r_state;
    logic [CW-1:0]       r_count;
    srt_pkg::t_cmd       r_cmd;
    logic [CB-1:0]       r_qx;
    logic [CB-1:0]       r_qy;
    logic [AW-1:0]       r_idx;
    logic [CW-1:0]       r_left;
    logic                r_dvld;
    logic                r_dlast;
    logic [AW-1:0]       r_didx;
    logic [AW-1:0]       r_hit_idx;
    logic [WW-1:0]       r_rd;
    logic [WW-1:0]       r_mem [TABLE_ENTRIES];

    logic                r_hit;
    logic                r_full;
    logic [IB-1:0]       r_id;
    logic [CB-1:0]       r_lx;
    logic [CB-1:0]       r_ty;
    logic [FB-1:0]       r_fl;

    logic                r_ovld;
    logic                r_o_hit;
    logic                r_o_full;
    logic [IB-1:0]       r_o_id;
    logic [CB-1:0]       r_o_lx;
    logic [CB-1:0]       r_o_ty;
    logic [FB-1:0]       r_o_fl;
    logic [OB-1:0]       r_o_cnt;

    logic                accept;
    logic                is_full;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [WW-1:0]       wr_data;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       last_addr;
    logic                out_load;
    logic [CW+OB-1:0]    cnt_ext;

    logic [CB-1:0]       e_x;
    logic [CB-1:0]       e_y;
    logic [CB-1:0]       e_w;
    logic [CB-1:0]       e_h;
    logic [FB-1:0]       e_fl;
    logic [IB-1:0]       e_id;
    logic [CB:0]         dx;
    logic [CB:0]         dy;
    logic                hit_now;

    assign accept    = i_in.valid && i_in.ready;
    assign is_full   = (r_count == CW'(TABLE_ENTRIES));
    assign last_addr = AW'(r_count - CW'(1));
    assign rd_addr   = (r_state == ST_SCAN) ? r_idx : last_addr;
    assign out_load  = (r_state == ST_OUT) && (!r_ovld || o_out.ready);
    assign cnt_ext   = {{OB{1'b0}}, r_count};

    assign i_in.ready = (r_state == ST_IDLE);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_count[AW-1:0];
        wr_data = {i_in.stamp_id, i_in.flip_flags, i_in.stamp_height, i_in.stamp_width,
                   i_in.pos_y, i_in.pos_x};
        if (accept && i_in.command == srt_pkg::CMD_INSERT && !is_full) begin
            wr_en = 1'b1;
        end else if (r_state == ST_MOVE_WR) begin
            wr_en   = 1'b1;
            wr_addr = r_hit_idx;
            wr_data = r_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    // containment: x - left must not borrow and must stay below width
    assign e_x  = r_rd[CB-1:0];
    assign e_y  = r_rd[2*CB-1:CB];
    assign e_w  = r_rd[3*CB-1:2*CB];
    assign e_h  = r_rd[4*CB-1:3*CB];
    assign e_fl = r_rd[4*CB+FB-1:4*CB];
    assign e_id = r_rd[WW-1:4*CB+FB];
    assign dx   = {1'b0, r_qx} - {1'b0, e_x};
    assign dy   = {1'b0, r_qy} - {1'b0, e_y};
    assign hit_now = !dx[CB] && !dy[CB] && (dx[CB-1:0] < e_w) && (dy[CB-1:0] < e_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_dvld  <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            if (out_load) begin
                r_ovld <= 1'b1;
            end else if (o_out.ready) begin
                r_ovld <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_cmd  <= i_in.command;
                        r_qx   <= i_in.pos_x;
                        r_qy   <= i_in.pos_y;
                        r_hit  <= 1'b0;
                        r_full <= 1'b0;
                        r_id   <= '0;
                        r_lx   <= '0;
                        r_ty   <= '0;
                        r_fl   <= '0;
                        r_dvld <= 1'b0;
                        r_left <= r_count;
                        r_idx  <= (i_in.command == srt_pkg::CMD_FIND) ? last_addr : '0;
                        r_state <= ST_OUT;
                        if (i_in.command == srt_pkg::CMD_INSERT) begin
                            if (is_full) begin
                                r_full <= 1'b1;
                            end else begin
                                r_count <= r_count + CW'(1);
                            end
                        end else if ((i_in.command == srt_pkg::CMD_FIND ||
                                      i_in.command == srt_pkg::CMD_REMOVE) &&
                                     r_count != '0) begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (r_left != '0) begin
                        r_dvld  <= 1'b1;
                        r_didx  <= r_idx;
                        r_dlast <= (r_left == CW'(1));
                        r_left  <= r_left - CW'(1);
                        r_idx   <= (r_cmd == srt_pkg::CMD_FIND) ? r_idx - AW'(1)
                                                                : r_idx + AW'(1);
                    end else begin
                        r_dvld <= 1'b0;
                    end
                    if (r_dvld && hit_now) begin
                        r_hit <= 1'b1;
                        r_id  <= e_id;
                        r_lx  <= e_x;
                        r_ty  <= e_y;
                        if (r_cmd == srt_pkg::CMD_FIND) begin
                            r_fl    <= e_fl;
                            r_state <= ST_OUT;
                        end else begin
                            r_hit_idx <= r_didx;
                            r_state   <= ST_MOVE_RD;
                        end
                    end else if (r_dvld && r_dlast) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_MOVE_RD: begin
                    r_dvld  <= 1'b0;
                    r_state <= ST_MOVE_WR;
                end
                ST_MOVE_WR: begin
                    r_count <= r_count - CW'(1);
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_hit  <= r_hit;
            r_o_full <= r_full;
            r_o_id   <= r_id;
            r_o_lx   <= r_lx;
            r_o_ty   <= r_ty;
            r_o_fl   <= r_fl;
            r_o_cnt  <= cnt_ext[OB-1:0];
        end
    end

    assign o_out.valid       = r_ovld;
    assign o_out.hit         = r_o_hit;
    assign o_out.table_full  = r_o_full;
    assign o_out.found_id    = r_o_id;
    assign o_out.left_x      = r_o_lx;
    assign o_out.top_y       = r_o_ty;
    assign o_out.found_flags = r_o_fl;
    assign o_out.entry_count = r_o_cnt;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_ENTRIES))
        else $error("entry count beyond table size");

    a_remove_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MOVE_WR) |=> (r_count == $past(r_count) - CW'(1)))
        else $error("remove did not drop one entry");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_in.command == srt_pkg::CMD_INSERT && is_full) |=>
        (r_full && $stable(r_count)))
        else $error("insert into full table not flagged");

    a_scan_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_dvld) |-> (CW'(r_didx) < r_count))
        else $error("scan read outside held entries");

    a_hit_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MOVE_RD) |-> (r_hit && r_cmd == srt_pkg::CMD_REMOVE))
        else $error("entry move without a remove hit");

endmodule
